// ===== hw/rtl/pdg_pkg.sv =====
// Shared types, constants and the sequencer microcode for the grid dart test.
package pdg_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned CELL_W     = 7;
  localparam int unsigned RADSQ_W    = 32;
  localparam int unsigned GSIDE_W    = 8;
  localparam int unsigned SIDE_W     = 9;
  localparam int unsigned RUN_W      = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STEP_W     = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE = 1'b1;

  localparam logic [RADSQ_W-1:0] RADIUS_SQ_RST = 32'd429025;
  localparam logic [GSIDE_W-1:0] GRID_SIDE_RST = 8'd128;

  localparam logic OP_TEST   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef logic [STEP_W-1:0] step_t;
  typedef logic signed [2:0] ofs_t;

  localparam step_t STEP_CLEAR = 5'd0;
  localparam step_t STEP_WAIT  = 5'd1;
  localparam step_t STEP_DONE  = 5'd26;
  localparam step_t STEP_LAST  = 5'd26;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_CLR_DONE,
    COND_REQ,
    COND_OUT_FREE
  } cond_t;

  // one stored sample: x in the low half, y in the high half
  typedef struct packed {
    logic               occ;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } cell_t;

  typedef struct packed {
    logic  clr;    // clearing pass over the cell memory
    logic  start;  // ready for a request
    logic  rd;     // read the cell at (row+dr, col+dc)
    logic  own;    // that read is the candidate's own cell
    ofs_t  dr;
    ofs_t  dc;
    logic  done;   // result and insert
    cond_t cond;   // stay on this step until cond holds
    logic  jump;   // then go to tgt instead of the next step
    step_t tgt;
  } ctl_t;

  typedef struct packed {
    logic clr_done;
    logic req;
    logic out_free;
  } seq_stat_t;

  function automatic ctl_t rd_at(ofs_t r, ofs_t c);
    ctl_t w;
    w = '0;
    w.rd = 1'b1;
    w.dr = r;
    w.dc = c;
    return w;
  endfunction

  function automatic ctl_t ucode_rom(step_t step);
    ctl_t w;
    w = '0;
    w.cond = COND_ALWAYS;
    unique case (step)
      STEP_CLEAR: begin
        w.clr  = 1'b1;
        w.cond = COND_CLR_DONE;
      end
      STEP_WAIT: begin
        w.start = 1'b1;
        w.cond  = COND_REQ;
      end
      5'd2: begin
        w     = rd_at(3'sd0, 3'sd0);
        w.own = 1'b1;
      end
      5'd3:  w = rd_at(-3'sd2, -3'sd1);
      5'd4:  w = rd_at(-3'sd2,  3'sd0);
      5'd5:  w = rd_at(-3'sd2,  3'sd1);
      5'd6:  w = rd_at(-3'sd1, -3'sd2);
      5'd7:  w = rd_at(-3'sd1, -3'sd1);
      5'd8:  w = rd_at(-3'sd1,  3'sd0);
      5'd9:  w = rd_at(-3'sd1,  3'sd1);
      5'd10: w = rd_at(-3'sd1,  3'sd2);
      5'd11: w = rd_at( 3'sd0, -3'sd2);
      5'd12: w = rd_at( 3'sd0, -3'sd1);
      5'd13: w = rd_at( 3'sd0,  3'sd1);
      5'd14: w = rd_at( 3'sd0,  3'sd2);
      5'd15: w = rd_at( 3'sd1, -3'sd2);
      5'd16: w = rd_at( 3'sd1, -3'sd1);
      5'd17: w = rd_at( 3'sd1,  3'sd0);
      5'd18: w = rd_at( 3'sd1,  3'sd1);
      5'd19: w = rd_at( 3'sd1,  3'sd2);
      5'd20: w = rd_at( 3'sd2, -3'sd1);
      5'd21: w = rd_at( 3'sd2,  3'sd0);
      5'd22: w = rd_at( 3'sd2,  3'sd1);
      5'd23, 5'd24, 5'd25: w.cond = COND_ALWAYS; // distance pipe drains
      STEP_DONE: begin
        w.done = 1'b1;
        w.cond = COND_OUT_FREE;
        w.jump = 1'b1;
        w.tgt  = STEP_WAIT;
      end
      default: begin
        w.jump = 1'b1;
        w.tgt  = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/pdg_ifs.sv =====
// Request and result channel interfaces.
interface pdg_req_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [pdg_pkg::CELL_W-1:0]   cell_row;
  logic [pdg_pkg::CELL_W-1:0]   cell_col;
  logic [pdg_pkg::COORD_W-1:0]  point_x;
  logic [pdg_pkg::COORD_W-1:0]  point_y;

  modport source(output valid, opcode, cell_row, cell_col, point_x, point_y, input ready);
  modport sink(input valid, opcode, cell_row, cell_col, point_x, point_y, output ready);
endinterface

interface pdg_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       is_free;
  logic [pdg_pkg::RUN_W-1:0]  reject_run;

  modport source(output valid, is_free, reject_run, input ready);
  modport sink(input valid, is_free, reject_run, output ready);
endinterface

// ===== hw/rtl/pdg_cell_mem.sv =====
// Cell memory: occupied flag and stored point, with a clearing pass after reset.
module pdg_cell_mem #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr_en,
  output logic               clr_done,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output pdg_pkg::cell_t     rd_data,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  pdg_pkg::cell_t     wr_data
);

  pdg_pkg::cell_t mem [DEPTH];
  pdg_pkg::cell_t rd_data_r;
  logic [AW-1:0]  clr_cnt_r;

  assign clr_done = (clr_cnt_r == AW'(DEPTH - 1));
  assign rd_data  = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clr_en) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_en) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/pdg_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
module pdg_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  pdg_pkg::seq_stat_t  stat,
  output pdg_pkg::ctl_t       ctl
);

  pdg_pkg::step_t step_r;
  pdg_pkg::step_t step_nxt;
  logic           cond_ok;

  assign ctl = pdg_pkg::ucode_rom(step_r);

  always_comb begin
    unique case (ctl.cond)
      pdg_pkg::COND_ALWAYS:   cond_ok = 1'b1;
      pdg_pkg::COND_CLR_DONE: cond_ok = stat.clr_done;
      pdg_pkg::COND_REQ:      cond_ok = stat.req;
      pdg_pkg::COND_OUT_FREE: cond_ok = stat.out_free;
      default:                cond_ok = 1'b1;
    endcase
    if (!cond_ok) begin
      step_nxt = step_r;
    end else if (ctl.jump) begin
      step_nxt = ctl.tgt;
    end else begin
      step_nxt = pdg_pkg::step_t'(step_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= pdg_pkg::STEP_CLEAR;
    end else begin
      step_r <= step_nxt;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= pdg_pkg::STEP_LAST)
    else $error("sequencer left the program");

  a_req_then_own: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.req && ctl.start) |=> (ctl.rd && ctl.own))
    else $error("own cell read does not follow a request");

endmodule

// ===== hw/rtl/pdg_datapath.sv =====
// Datapath: candidate latch, cell addressing, distance pipe and reject counter.
module pdg_datapath #(
  parameter int unsigned GRID_MAX_SIDE = 128,
  parameter int unsigned AW            = 14
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pdg_pkg::ctl_t                   ctl,
  input  logic                            in_fire,
  input  logic                            done_fire,
  input  logic                            opcode,
  input  logic [pdg_pkg::CELL_W-1:0]      cell_row,
  input  logic [pdg_pkg::CELL_W-1:0]      cell_col,
  input  logic [pdg_pkg::COORD_W-1:0]     point_x,
  input  logic [pdg_pkg::COORD_W-1:0]     point_y,
  input  logic [pdg_pkg::RADSQ_W-1:0]     radius_sq,
  input  logic [pdg_pkg::SIDE_W-1:0]      side_eff,
  input  pdg_pkg::cell_t                  rd_data,
  output logic                            rd_en,
  output logic [AW-1:0]                   rd_addr,
  output logic                            wr_en,
  output logic [AW-1:0]                   wr_addr,
  output pdg_pkg::cell_t                  wr_data,
  output logic                            res_free,
  output logic [pdg_pkg::RUN_W-1:0]       res_run
);

  localparam int unsigned SW = pdg_pkg::SIDE_W;
  localparam int unsigned CW = pdg_pkg::COORD_W;

  logic                        op_r;
  logic [pdg_pkg::CELL_W-1:0]  row_r, col_r;
  logic [CW-1:0]               px_r, py_r;

  logic signed [SW:0]          nr, nc;
  logic                        nb_ok;
  logic                        in_grid;

  logic                        s1_v_r, s1_own_r;
  logic                        s2_v_r, s2_own_r;
  logic [CW-1:0]               s2_dx_r, s2_dy_r;
  logic                        s3_v_r, s3_own_r;
  logic [2*CW-1:0]             s3_dx2_r, s3_dy2_r;
  logic [2*CW:0]               dist_sq;
  logic                        close;
  logic                        hit_r;
  logic [pdg_pkg::RUN_W-1:0]   rej_r, rej_nxt;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= opcode;
      row_r <= cell_row;
      col_r <= cell_col;
      px_r  <= point_x;
      py_r  <= point_y;
    end
  end

  // neighbor position, signed so that cells above or left of the grid show up
  assign nr    = $signed((SW+1)'(row_r)) + (SW+1)'(ctl.dr);
  assign nc    = $signed((SW+1)'(col_r)) + (SW+1)'(ctl.dc);
  assign nb_ok = !nr[SW] && !nc[SW] && (nr[SW-1:0] < side_eff) && (nc[SW-1:0] < side_eff);

  assign rd_en   = ctl.rd && nb_ok;
  assign rd_addr = AW'(AW'(nr[SW-1:0]) * AW'(GRID_MAX_SIDE)) + AW'(nc[SW-1:0]);

  assign in_grid = (SW'(row_r) < side_eff) && (SW'(col_r) < side_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= rd_en;
      s2_v_r <= s1_v_r && rd_data.occ;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_own_r <= ctl.own;
    s2_own_r <= s1_own_r;
    s2_dx_r  <= (px_r > rd_data.x) ? px_r - rd_data.x : rd_data.x - px_r;
    s2_dy_r  <= (py_r > rd_data.y) ? py_r - rd_data.y : rd_data.y - py_r;
    s3_own_r <= s2_own_r;
    s3_dx2_r <= s2_dx_r * s2_dx_r;
    s3_dy2_r <= s2_dy_r * s2_dy_r;
  end

  assign dist_sq = {1'b0, s3_dx2_r} + {1'b0, s3_dy2_r};
  assign close   = dist_sq <= (2*CW+1)'(radius_sq);

  // an occupied own cell rejects at any distance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (in_fire) begin
      hit_r <= 1'b0;
    end else if (s3_v_r && (s3_own_r || close)) begin
      hit_r <= 1'b1;
    end
  end

  assign res_free = in_grid && !hit_r;

  always_comb begin
    if (res_free) begin
      rej_nxt = '0;
    end else if (rej_r == '1) begin
      rej_nxt = rej_r;
    end else begin
      rej_nxt = rej_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rej_r <= '0;
    end else if (done_fire) begin
      rej_r <= rej_nxt;
    end
  end

  assign res_run = rej_nxt;

  assign wr_en        = done_fire && res_free && (op_r == pdg_pkg::OP_INSERT);
  assign wr_addr      = AW'(AW'(row_r) * AW'(GRID_MAX_SIDE)) + AW'(col_r);
  assign wr_data.occ  = 1'b1;
  assign wr_data.y    = py_r;
  assign wr_data.x    = px_r;

endmodule

// ===== hw/rtl/poisson_disk_grid_dart_test.sv =====
// Top level of the Poisson-disk background-grid dart test.
//
// Requests arrive on in_ch: opcode, the candidate's cell row and column and
// its point. Each request gives one result on out_ch: is_free and the run of
// consecutive rejections. Opcode insert also stores a free candidate in its
// cell. The user must write radius_sq and grid_side on the cfg_ port only
// while idle; the block itself does not enforce this.
//
// A request runs to its result before the next one is taken. The pace is set
// by the single read port of the cell memory (own cell plus twenty neighbors,
// one read per cycle) and the four-stage distance pipe behind it.
//
// After reset the sequencer clears all GRID_MAX_SIDE*GRID_MAX_SIDE cells of the
// cell memory (16384 at the default), one cell per cycle; in_ch.ready stays
// low until then. Config writes are taken at any time.
//
// The result sits in an output register. A new request is accepted while it
// waits; the following result is held back until out_ch takes the old one.
module poisson_disk_grid_dart_test #(
  parameter int unsigned GRID_MAX_SIDE = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  pdg_req_if.sink                            in_ch,
  pdg_rsp_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [pdg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pdg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned DEPTH = GRID_MAX_SIDE * GRID_MAX_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SW    = pdg_pkg::SIDE_W;

  logic [pdg_pkg::RADSQ_W-1:0]  radius_sq_r;
  logic [pdg_pkg::GSIDE_W-1:0]  grid_side_r;
  logic [SW-1:0]                side_eff;

  pdg_pkg::ctl_t                ctl;
  pdg_pkg::seq_stat_t           stat;
  logic                         in_fire, done_fire, out_free;
  logic                         clr_done;

  logic                         rd_en, wr_en;
  logic [AW-1:0]                rd_addr, wr_addr;
  pdg_pkg::cell_t               rd_data, wr_data;
  logic                         res_free;
  logic [pdg_pkg::RUN_W-1:0]    res_run;

  logic                         out_valid_r;
  logic                         out_free_r;
  logic [pdg_pkg::RUN_W-1:0]    out_run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_sq_r <= pdg_pkg::RADIUS_SQ_RST;
      grid_side_r <= pdg_pkg::GRID_SIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pdg_pkg::CFG_RADIUS_SQ: radius_sq_r <= cfg_wdata[pdg_pkg::RADSQ_W-1:0];
        pdg_pkg::CFG_GRID_SIDE: grid_side_r <= cfg_wdata[pdg_pkg::GSIDE_W-1:0];
      endcase
    end
  end

  assign side_eff = (SW'(grid_side_r) > SW'(GRID_MAX_SIDE)) ? SW'(GRID_MAX_SIDE)
                                                            : SW'(grid_side_r);

  assign in_ch.ready = ctl.start;
  assign in_fire     = in_ch.valid && ctl.start;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign done_fire   = ctl.done && out_free;

  assign stat.clr_done = clr_done;
  assign stat.req      = in_ch.valid;
  assign stat.out_free = out_free;

  pdg_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  pdg_cell_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_en   (ctl.clr),
    .clr_done (clr_done),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  pdg_datapath #(
    .GRID_MAX_SIDE (GRID_MAX_SIDE),
    .AW            (AW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_fire   (in_fire),
    .done_fire (done_fire),
    .opcode    (in_ch.opcode),
    .cell_row  (in_ch.cell_row),
    .cell_col  (in_ch.cell_col),
    .point_x   (in_ch.point_x),
    .point_y   (in_ch.point_y),
    .radius_sq (radius_sq_r),
    .side_eff  (side_eff),
    .rd_data   (rd_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_free  (res_free),
    .res_run   (res_run)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_free_r <= res_free;
      out_run_r  <= res_run;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.is_free    = out_free_r;
  assign out_ch.reject_run = out_run_r;

  a_clr_no_insert: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |-> (!wr_en && !in_ch.ready))
    else $error("insert or request during memory clear");

  a_free_zero_run: assert property (@(posedge clk) disable iff (!rst_n)
    (done_fire && res_free) |=> (out_valid_r && out_free_r && out_run_r == '0))
    else $error("accepted candidate without a cleared reject run");

endmodule
